>>> rtl/klm_pkg.sv
`timescale 1ns / 1ps
package klm_pkg;
    localparam int unsigned FUNC_W = 3;
    localparam logic [FUNC_W-1:0] FN_LOAD_PT  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_LOAD_CEN = 3'd1;
    localparam logic [FUNC_W-1:0] FN_RUN      = 3'd2;
    localparam logic [FUNC_W-1:0] FN_RD_CLASS = 3'd3;
    localparam logic [FUNC_W-1:0] FN_RD_CEN   = 3'd4;
    localparam int unsigned ROW_W     = 10;
    localparam int unsigned DIM_W     = 3;
    localparam int unsigned VAL_W     = 16;
    localparam int unsigned CHANGES_W = 11;
    localparam int unsigned SHIFT_W   = 35;
    localparam int unsigned CLASS_W   = 4;
    localparam int unsigned KREG_W    = 4;
    localparam int unsigned DREG_W    = 4;
    localparam int unsigned PREG_W    = 11;
    localparam logic [1:0] REG_K = 2'd0;
    localparam logic [1:0] REG_D = 2'd1;
    localparam logic [1:0] REG_P = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ROW_W-1:0]  row;
        logic [DIM_W-1:0]  dim;
        logic signed [VAL_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic [CHANGES_W-1:0] changes;
        logic [SHIFT_W-1:0]   max_shift_sq;
        logic [CLASS_W-1:0]   class_id;
        logic signed [VAL_W-1:0] coord;
    } t_out_word;
endpackage

>>> rtl/klm_if.sv
`timescale 1ns / 1ps
interface klm_in_if;
    logic valid;
    logic ready;
    klm_pkg::t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface klm_out_if;
    logic valid;
    logic ready;
    klm_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/klm_ram.sv
`timescale 1ns / 1ps
module klm_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

>>> rtl/klm_cell.sv
`timescale 1ns / 1ps
// one cluster cell: holds its centroid, accumulates distance to the passing point,
// keeps the best-so-far in the chain, and accumulates member sums and count
module klm_cell #(
    parameter int unsigned MAX_DIMS   = 8,
    parameter int unsigned COORD_BITS = 16,
    parameter int unsigned CNT_W      = 11,
    parameter int unsigned IDX_W      = 3
) (
    input  logic                         i_clk,
    input  logic [IDX_W-1:0]             i_my_idx,
    input  logic                         i_active,
    // centroid write / read (dimension index)
    input  logic                         i_cen_we,
    input  logic [$clog2(MAX_DIMS+1)-1:0] i_cen_dim,
    input  logic signed [COORD_BITS-1:0] i_cen_wdata,
    output logic signed [COORD_BITS-1:0] o_cen_rdata,
    // distance phase: one coordinate per cycle, shared across cells
    input  logic                         i_dist_clr,
    input  logic                         i_dist_en,
    input  logic [$clog2(MAX_DIMS+1)-1:0] i_dist_dim,
    input  logic signed [COORD_BITS-1:0] i_pt_coord,
    // compare chain, handed from the previous cell
    input  logic                         i_cmp_en,
    input  logic [2*COORD_BITS+6:0]      i_best_d,
    input  logic [IDX_W-1:0]             i_best_idx,
    input  logic                         i_best_vld,
    output logic [2*COORD_BITS+6:0]      o_best_d,
    output logic [IDX_W-1:0]             o_best_idx,
    output logic                         o_best_vld,
    // accumulation
    input  logic                         i_acc_clr,
    input  logic                         i_acc_en,
    input  logic [IDX_W-1:0]             i_win_idx,
    input  logic [$clog2(MAX_DIMS+1)-1:0] i_acc_dim,
    input  logic                         i_cnt_en,
    output logic signed [COORD_BITS+CNT_W-1:0] o_sum,
    output logic [CNT_W-1:0]             o_cnt
);
    localparam int unsigned DIST_W = 2*COORD_BITS+7;
    localparam int unsigned SUM_W  = COORD_BITS+CNT_W;
    localparam int unsigned DI_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    logic signed [COORD_BITS-1:0] r_cen [MAX_DIMS];
    logic signed [SUM_W-1:0]      r_sum [MAX_DIMS];
    logic [CNT_W-1:0]             r_cnt;
    logic [DIST_W-1:0]            r_dist;
    logic signed [COORD_BITS:0]   diff;
    logic [2*COORD_BITS+1:0]      sq;
    logic [DI_W-1:0]              cdi, ddi, adi;
    logic                         better;

    assign cdi = i_cen_dim[DI_W-1:0];
    assign ddi = i_dist_dim[DI_W-1:0];
    assign adi = i_acc_dim[DI_W-1:0];
    assign o_cen_rdata = r_cen[cdi];
    assign diff = $signed({i_pt_coord[COORD_BITS-1], i_pt_coord})
                  - $signed({r_cen[ddi][COORD_BITS-1], r_cen[ddi]});
    assign sq = (2*COORD_BITS+2)'($signed(diff) * $signed(diff));
    assign better = i_active && (!i_best_vld || (r_dist < i_best_d));
    assign o_sum = r_sum[adi];
    assign o_cnt = r_cnt;

    // centroid storage
    always_ff @(posedge i_clk) begin
        if (i_cen_we) begin
            r_cen[cdi] <= i_cen_wdata;
        end
    end

    // distance accumulator
    always_ff @(posedge i_clk) begin
        if (i_dist_clr) begin
            r_dist <= '0;
        end else if (i_dist_en) begin
            r_dist <= r_dist + DIST_W'(sq);
        end
    end

    // compare stage, registered hand-off to the next cell
    always_ff @(posedge i_clk) begin
        if (i_cmp_en) begin
            o_best_vld <= i_best_vld || i_active;
            if (better) begin
                o_best_d   <= r_dist;
                o_best_idx <= i_my_idx;
            end else begin
                o_best_d   <= i_best_d;
                o_best_idx <= i_best_idx;
            end
        end
    end

    // member sums and count
    always_ff @(posedge i_clk) begin
        if (i_acc_clr) begin
            for (int j = 0; j < MAX_DIMS; j++) begin
                r_sum[j] <= '0;
            end
            r_cnt <= '0;
        end else if (i_win_idx == i_my_idx) begin
            if (i_acc_en) begin
                r_sum[adi] <= r_sum[adi] + SUM_W'(i_pt_coord);
            end
            if (i_cnt_en) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end
endmodule

>>> rtl/klm_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, truncating signed result
module klm_div #(
    parameter int unsigned NUM_W = 27,
    parameter int unsigned DEN_W = 11
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0]        i_den,
    output logic                    o_done,
    output logic signed [NUM_W-1:0] o_quo
);
    localparam int unsigned CW = $clog2(NUM_W+1);
    logic [NUM_W-1:0] r_q, n_q;
    logic [DEN_W:0]   r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic             r_neg, r_busy, r_done;
    logic [CW-1:0]    r_cnt;
    logic [DEN_W:0]   trial;

    assign trial = {r_rem[DEN_W-1:0], r_q[NUM_W-1]};
    always_comb begin
        n_q   = {r_q[NUM_W-2:0], 1'b0};
        n_rem = trial;
        if (trial >= {1'b0, r_den}) begin
            n_rem = trial - {1'b0, r_den};
            n_q[0] = 1'b1;
        end
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
                r_neg  <= i_num[NUM_W-1];
                r_q    <= i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_quo  = r_neg ? -$signed(r_q) : $signed(r_q);
endmodule

>>> rtl/kmeans_lloyd_iteration.sv
`timescale 1ns / 1ps
// channel | dir | handshake   | word
// s_in    | in  | valid/ready | func, row, dim, value
// m_out   | out | valid/ready | changes, max_shift_sq, class_id, coord
// apb     | in  | psel/penable| cluster_count, dim_count, point_count
// loads stay in the idle state; reads pass through ST_RDWT and ST_OUT, then hold the input
// until the word is taken. a run classifies every point in use, then divides each dimension
// of every nonempty cluster in the shared divider, skipping empty clusters, and registers
// the word; with no points in use it answers at once.
// reset is synchronous, active low; the class store is cleared after reset in ST_CLEAR,
// no item is taken then. a waiting result blocks only new input.
module kmeans_lloyd_iteration #(
    parameter int unsigned MAX_POINTS   = 1024,
    parameter int unsigned MAX_DIMS     = 8,
    parameter int unsigned MAX_CLUSTERS = 8,
    parameter int unsigned COORD_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    klm_in_if.sink      s_in,
    klm_out_if.source   m_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import klm_pkg::*;

    localparam int unsigned PI_W  = $clog2(MAX_POINTS);
    localparam int unsigned DI_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int unsigned DC_W  = $clog2(MAX_DIMS+1);
    localparam int unsigned KI_W  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int unsigned KC_W  = $clog2(MAX_CLUSTERS+1);
    localparam int unsigned PC_W  = $clog2(MAX_POINTS+1);
    localparam int unsigned CNT_W = PC_W;
    localparam int unsigned SUM_W = COORD_BITS+CNT_W;
    localparam int unsigned DIST_W = 2*COORD_BITS+7;
    localparam int unsigned PM_D  = MAX_POINTS*(1 << DI_W);
    localparam int unsigned PA_W  = $clog2(PM_D);
    localparam int unsigned CL_W  = $clog2(MAX_CLUSTERS+1);

    typedef enum logic [10:0] {
        ST_CLEAR = 11'b00000000001,
        ST_IDLE  = 11'b00000000010,
        ST_RDCL  = 11'b00000000100,
        ST_DIST  = 11'b00000001000,
        ST_CMP   = 11'b00000010000,
        ST_ACC   = 11'b00000100000,
        ST_DIVST = 11'b00001000000,
        ST_DIVW  = 11'b00010000000,
        ST_SHIFT = 11'b00100000000,
        ST_OUT   = 11'b01000000000,
        ST_RDWT  = 11'b10000000000
    } t_state;

    t_state r_st;
    logic [KREG_W-1:0] r_kreg;
    logic [DREG_W-1:0] r_dreg;
    logic [PREG_W-1:0] r_preg;
    logic [KC_W-1:0]   k_use;
    logic [DC_W-1:0]   d_use;
    logic [PC_W-1:0]   p_use;

    // apb registers
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kreg <= KREG_W'(2);
            r_dreg <= DREG_W'(2);
            r_preg <= PREG_W'(1024);
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_K:   r_kreg <= pwdata[KREG_W-1:0];
                REG_D:   r_dreg <= pwdata[DREG_W-1:0];
                REG_P:   r_preg <= pwdata[PREG_W-1:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        case (paddr[3:2])
            REG_K:   prdata = 32'(r_kreg);
            REG_D:   prdata = 32'(r_dreg);
            REG_P:   prdata = 32'(r_preg);
            default: prdata = '0;
        endcase
    end
    assign k_use = (r_kreg == '0) ? KC_W'(1) :
                   (32'(r_kreg) > MAX_CLUSTERS) ? KC_W'(MAX_CLUSTERS) : KC_W'(r_kreg);
    assign d_use = (r_dreg == '0) ? DC_W'(1) :
                   (32'(r_dreg) > MAX_DIMS) ? DC_W'(MAX_DIMS) : DC_W'(r_dreg);
    assign p_use = (32'(r_preg) > MAX_POINTS) ? PC_W'(MAX_POINTS) : PC_W'(r_preg);

    // working registers
    t_in_word          r_item;
    logic [PC_W-1:0]   r_pi;
    logic [DC_W-1:0]   r_dj;
    logic [KC_W:0]     r_kc;
    logic [CHANGES_W-1:0] r_changes;
    logic [SHIFT_W-1:0]   r_maxsh;
    logic [DIST_W-1:0]    r_shacc;
    logic [CLASS_W-1:0]   r_class_rd;
    logic signed [COORD_BITS-1:0] r_coord_rd;
    logic              r_ovalid;
    t_out_word         r_odata;
    logic              r_rd_sel;

    logic in_fire;
    assign s_in.ready = (r_st == ST_IDLE) && !r_ovalid;
    assign in_fire = s_in.valid && s_in.ready;

    // point memory
    logic             pm_we;
    logic [PA_W-1:0]  pm_waddr, pm_raddr;
    logic [COORD_BITS-1:0] pm_rdata;
    assign pm_we = in_fire && (s_in.data.func == FN_LOAD_PT)
                   && (32'(s_in.data.row) < MAX_POINTS) && (32'(s_in.data.dim) < MAX_DIMS);
    assign pm_waddr = PA_W'({PI_W'(s_in.data.row), DI_W'(s_in.data.dim)});
    assign pm_raddr = PA_W'({r_pi[PI_W-1:0], r_dj[DI_W-1:0]});
    klm_ram #(.WIDTH(COORD_BITS), .DEPTH(PM_D)) u_pts (
        .i_clk(i_clk), .i_we(pm_we), .i_waddr(pm_waddr),
        .i_wdata(COORD_BITS'(s_in.data.value)), .i_raddr(pm_raddr), .o_rdata(pm_rdata)
    );

    // class memory
    logic             cm_we;
    logic [PI_W-1:0]  cm_waddr, cm_raddr;
    logic [CL_W-1:0]  cm_wdata, cm_rdata;
    logic [KI_W-1:0]  win_idx;

    // cell chain
    logic [DIST_W-1:0] ch_d   [MAX_CLUSTERS+1];
    logic [KI_W-1:0]   ch_idx [MAX_CLUSTERS+1];
    logic              ch_vld [MAX_CLUSTERS+1];
    logic signed [COORD_BITS-1:0] cen_rd [MAX_CLUSTERS];
    logic signed [SUM_W-1:0]      sum_rd [MAX_CLUSTERS];
    logic [CNT_W-1:0]             cnt_rd [MAX_CLUSTERS];
    logic [MAX_CLUSTERS-1:0]      cen_we;
    logic [DC_W-1:0] cen_dim;
    logic signed [COORD_BITS-1:0] cen_wdata;
    logic [DC_W-1:0] r_pdj;
    logic [DC_W-1:0] acc_dim;
    logic r_dist_en, r_acc_en, r_cnt_en;
    logic signed [COORD_BITS-1:0] mean;
    logic div_start, div_done;
    logic signed [SUM_W-1:0] div_q;
    logic [KI_W-1:0] kc_i;
    assign kc_i = r_kc[KI_W-1:0];

    assign ch_d[0] = '0;
    assign ch_idx[0] = '0;
    assign ch_vld[0] = 1'b0;
    assign win_idx = ch_idx[MAX_CLUSTERS];

    // sums follow the delayed read while accumulating, the current dimension while dividing
    assign acc_dim = (r_st == ST_ACC) ? r_pdj : r_dj;

    genvar g;
    generate
        for (g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
            klm_cell #(.MAX_DIMS(MAX_DIMS), .COORD_BITS(COORD_BITS),
                       .CNT_W(CNT_W), .IDX_W(KI_W)) u_cell (
                .i_clk(i_clk), .i_my_idx(KI_W'(g)),
                .i_active(32'(g) < 32'(k_use)),
                .i_cen_we(cen_we[g]), .i_cen_dim(cen_dim), .i_cen_wdata(cen_wdata),
                .o_cen_rdata(cen_rd[g]),
                .i_dist_clr(r_st == ST_RDCL), .i_dist_en(r_dist_en),
                .i_dist_dim(r_pdj), .i_pt_coord($signed(pm_rdata)),
                .i_cmp_en(r_st == ST_CMP),
                .i_best_d(ch_d[g]), .i_best_idx(ch_idx[g]), .i_best_vld(ch_vld[g]),
                .o_best_d(ch_d[g+1]), .o_best_idx(ch_idx[g+1]), .o_best_vld(ch_vld[g+1]),
                .i_acc_clr(in_fire && s_in.data.func == FN_RUN),
                .i_acc_en(r_acc_en), .i_win_idx(win_idx), .i_acc_dim(acc_dim),
                .i_cnt_en(r_cnt_en), .o_sum(sum_rd[g]), .o_cnt(cnt_rd[g])
            );
        end
    endgenerate

    klm_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(sum_rd[kc_i]), .i_den(cnt_rd[kc_i]), .o_done(div_done), .o_quo(div_q)
    );
    assign mean = COORD_BITS'(div_q);
    assign div_start = (r_st == ST_DIVST) && (cnt_rd[kc_i] != '0);

    // centroid port mux: loads from input, updates from divider
    always_comb begin
        cen_we    = '0;
        cen_dim   = DC_W'(r_item.dim);
        cen_wdata = $signed(r_item.value);
        if (r_st == ST_SHIFT) begin
            cen_dim   = r_dj;
            cen_wdata = mean;
            cen_we[kc_i] = 1'b1;
        end else if (in_fire && s_in.data.func == FN_LOAD_CEN
                     && 32'(s_in.data.row) < MAX_CLUSTERS && 32'(s_in.data.dim) < MAX_DIMS) begin
            cen_dim   = DC_W'(s_in.data.dim);
            cen_wdata = $signed(s_in.data.value);
            cen_we[KI_W'(s_in.data.row)] = 1'b1;
        end
    end

    logic signed [COORD_BITS:0] sdiff;
    logic [2*COORD_BITS+1:0]    ssq;
    assign sdiff = $signed({cen_rd[kc_i][COORD_BITS-1], cen_rd[kc_i]})
                   - $signed({mean[COORD_BITS-1], mean});
    assign ssq = (2*COORD_BITS+2)'($signed(sdiff) * $signed(sdiff));

    klm_ram #(.WIDTH(CL_W), .DEPTH(MAX_POINTS)) u_cls (
        .i_clk(i_clk), .i_we(cm_we), .i_waddr(cm_waddr), .i_wdata(cm_wdata),
        .i_raddr(cm_raddr), .o_rdata(cm_rdata)
    );
    assign cm_raddr = (r_st == ST_IDLE) ? PI_W'(s_in.data.row) : r_pi[PI_W-1:0];
    always_comb begin
        cm_we    = 1'b0;
        cm_waddr = r_pi[PI_W-1:0];
        cm_wdata = '0;
        if (r_st == ST_CLEAR) begin
            cm_we = 1'b1;
        end else if (r_st == ST_ACC && r_dj == '0) begin
            cm_we    = 1'b1;
            cm_wdata = CL_W'(win_idx) + CL_W'(1);
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_CLEAR;
            r_pi     <= '0;
            r_ovalid <= 1'b0;
            r_dist_en <= 1'b0;
            r_acc_en  <= 1'b0;
            r_cnt_en  <= 1'b0;
        end else begin
            r_dist_en <= 1'b0;
            r_acc_en  <= 1'b0;
            r_cnt_en  <= 1'b0;
            r_pdj     <= r_dj;
            if (r_st == ST_OUT) begin
                r_ovalid <= 1'b1;
            end else if (m_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_st)
                ST_CLEAR: begin
                    r_pi <= r_pi + 1'b1;
                    if (32'(r_pi) == MAX_POINTS-1) begin
                        r_st <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_fire) begin
                        r_item <= s_in.data;
                        r_pi <= '0;
                        r_dj <= '0;
                        r_changes <= '0;
                        r_maxsh <= '0;
                        r_rd_sel <= 1'b0;
                        case (s_in.data.func)
                            FN_RUN: r_st <= (p_use == '0) ? ST_OUT : ST_RDCL;
                            FN_RD_CLASS: begin
                                r_rd_sel <= 1'b1;
                                r_st <= ST_RDWT;
                            end
                            FN_RD_CEN: r_st <= ST_RDWT;
                            default: r_st <= ST_IDLE;
                        endcase
                    end
                end
                ST_RDWT: begin
                    r_class_rd <= (32'(r_item.row) < MAX_POINTS) ? CLASS_W'(cm_rdata) : '0;
                    r_coord_rd <= (32'(r_item.row) < MAX_CLUSTERS
                                   && 32'(r_item.dim) < MAX_DIMS) ? cen_rd[KI_W'(r_item.row)]
                                                                  : '0;
                    r_st <= ST_OUT;
                end
                ST_RDCL: begin
                    r_dj <= '0;
                    r_st <= ST_DIST;
                end
                ST_DIST: begin
                    // issue reads d_use times; each is accumulated in the following cycle
                    if (r_dj != d_use) begin
                        r_dj <= r_dj + 1'b1;
                        r_dist_en <= 1'b1;
                    end else if (!r_dist_en) begin
                        r_kc <= '0;
                        r_st <= ST_CMP;
                    end
                end
                ST_CMP: begin
                    r_kc <= r_kc + 1'b1;
                    if (32'(r_kc) == MAX_CLUSTERS-1) begin
                        r_dj <= '0;
                        r_st <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    if (r_dj == '0) begin
                        r_cnt_en <= 1'b1;
                        if (cm_rdata != CL_W'(win_idx) + CL_W'(1)) begin
                            r_changes <= r_changes + 1'b1;
                        end
                    end
                    if (r_dj != d_use) begin
                        r_dj <= r_dj + 1'b1;
                        r_acc_en <= 1'b1;
                    end else if (!r_acc_en) begin
                        if (r_pi == p_use - 1'b1) begin
                            r_kc <= '0;
                            r_dj <= '0;
                            r_shacc <= '0;
                            r_st <= ST_DIVST;
                        end else begin
                            r_pi <= r_pi + 1'b1;
                            r_st <= ST_RDCL;
                        end
                    end
                end
                ST_DIVST: begin
                    if (cnt_rd[kc_i] == '0) begin
                        r_kc <= r_kc + 1'b1;
                        r_st <= (r_kc + 1'b1 == (KC_W+1)'(k_use)) ? ST_OUT : ST_DIVST;
                    end else begin
                        r_st <= ST_DIVW;
                    end
                end
                ST_DIVW: begin
                    if (div_done) begin
                        r_st <= ST_SHIFT;
                    end
                end
                ST_SHIFT: begin
                    if (r_dj + 1'b1 == d_use) begin
                        r_dj <= '0;
                        r_kc <= r_kc + 1'b1;
                        r_shacc <= '0;
                        if (SHIFT_W'(r_shacc + DIST_W'(ssq)) > r_maxsh) begin
                            r_maxsh <= SHIFT_W'(r_shacc + DIST_W'(ssq));
                        end
                        r_st <= (r_kc + 1'b1 == (KC_W+1)'(k_use)) ? ST_OUT : ST_DIVST;
                    end else begin
                        r_dj <= r_dj + 1'b1;
                        r_shacc <= r_shacc + DIST_W'(ssq);
                        r_st <= ST_DIVST;
                    end
                end
                ST_OUT: begin
                    if (r_item.func == FN_RUN) begin
                        r_odata.changes      <= r_changes;
                        r_odata.max_shift_sq <= r_maxsh;
                        r_odata.class_id     <= '0;
                        r_odata.coord        <= '0;
                    end else if (r_rd_sel) begin
                        r_odata.changes      <= '0;
                        r_odata.max_shift_sq <= '0;
                        r_odata.class_id     <= r_class_rd;
                        r_odata.coord        <= '0;
                    end else begin
                        r_odata.changes      <= '0;
                        r_odata.max_shift_sq <= '0;
                        r_odata.class_id     <= '0;
                        r_odata.coord        <= r_coord_rd;
                    end
                    r_st <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign m_out.valid = r_ovalid;
    assign m_out.data  = r_odata;

    // no new word while a result waits
    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !s_in.ready) else $error("input taken with result pending");
    // result appears only after the output state
    a_out_from_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_st == ST_OUT)) else $error("stray result");
    // divider completes only while waited on
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_st == ST_DIVW) else $error("divider done unexpected");
endmodule

>>> tb/sv/kmeans_predict_check.sv
`timescale 1ns / 1ps
module kmeans_predict_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    klm_in_if           in_mon,
    klm_out_if          out_mon,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output int          mismatch_count,
    output int          pending_words
);
    import klm_pkg::*;

    localparam int NPTS = 1024;
    localparam int NDIM = 8;
    localparam int NCLU = 8;

    // shadow copy of the engine state
    int                  pt_coord [NPTS*NDIM];
    int                  cen_coord [NCLU*NDIM];
    logic [CLASS_W-1:0]  class_of [NPTS];
    logic [KREG_W-1:0]   k_reg;
    logic [DREG_W-1:0]   d_reg;
    logic [PREG_W-1:0]   p_reg;
    t_out_word           expected_words [$];

    // one lloyd pass over the shadow state
    task automatic lloyd_pass(output t_out_word res);
        int               k;
        int               d;
        int               p;
        int               best;
        int               changes;
        int               cnt [NCLU];
        int               mean [NDIM];
        longint           sums [NCLU*NDIM];
        longint           diff;
        longint           dsq;
        longint           best_d;
        longint           top_shift;
        k = (k_reg == 0) ? 1 : ((k_reg > NCLU) ? NCLU : int'(k_reg));
        d = (d_reg == 0) ? 1 : ((d_reg > NDIM) ? NDIM : int'(d_reg));
        p = (p_reg > NPTS) ? NPTS : int'(p_reg);
        changes = 0;
        top_shift = 0;
        for (int c = 0; c < NCLU; c++) cnt[c] = 0;
        for (int s = 0; s < NCLU*NDIM; s++) sums[s] = 0;
        // nearest centroid, lowest index wins ties
        for (int i = 0; i < p; i++) begin
            best = 0;
            best_d = 0;
            for (int c = 0; c < k; c++) begin
                dsq = 0;
                for (int j = 0; j < d; j++) begin
                    diff = longint'(pt_coord[i*NDIM+j]) - longint'(cen_coord[c*NDIM+j]);
                    dsq += diff * diff;
                end
                if (c == 0 || dsq < best_d) begin
                    best_d = dsq;
                    best = c;
                end
            end
            if (class_of[i] != CLASS_W'(best + 1)) changes++;
            class_of[i] = CLASS_W'(best + 1);
            cnt[best]++;
            for (int j = 0; j < d; j++) sums[best*NDIM+j] += pt_coord[i*NDIM+j];
        end
        // centroid update, empty clusters stay put
        for (int c = 0; c < k; c++) begin
            if (cnt[c] != 0) begin
                dsq = 0;
                for (int j = 0; j < d; j++) begin
                    mean[j] = int'(sums[c*NDIM+j] / longint'(cnt[c]));
                    diff = longint'(cen_coord[c*NDIM+j]) - longint'(mean[j]);
                    dsq += diff * diff;
                end
                if (dsq > top_shift) top_shift = dsq;
                for (int j = 0; j < d; j++) cen_coord[c*NDIM+j] = mean[j];
            end
        end
        res = '0;
        res.changes = CHANGES_W'(changes);
        res.max_shift_sq = SHIFT_W'(top_shift);
    endtask

    // compare one result word against the oldest prediction
    task automatic check_word(input t_out_word got);
        t_out_word want;
        if (expected_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected result word: changes=%0d shift=%0d class=%0d coord=%0d",
                         got.changes, got.max_shift_sq, got.class_id, got.coord);
        end else begin
            want = expected_words.pop_front();
            if (got.changes !== want.changes || got.max_shift_sq !== want.max_shift_sq ||
                got.class_id !== want.class_id || got.coord !== want.coord) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display({"mismatch: exp changes=%0d shift=%0d class=%0d coord=%0d,",
                              " got changes=%0d shift=%0d class=%0d coord=%0d"},
                             want.changes, want.max_shift_sq, want.class_id, want.coord,
                             got.changes, got.max_shift_sq, got.class_id, got.coord);
            end
        end
    endtask

    // predict on every accepted input word
    task automatic predict_word(input t_in_word w);
        t_out_word res;
        res = '0;
        case (w.func)
            FN_LOAD_PT: pt_coord[w.row*NDIM + w.dim] = w.value;
            FN_LOAD_CEN: begin
                if (w.row < NCLU) cen_coord[w.row*NDIM + w.dim] = w.value;
            end
            FN_RUN: begin
                lloyd_pass(res);
                expected_words.push_back(res);
            end
            FN_RD_CLASS: begin
                res.class_id = class_of[w.row];
                expected_words.push_back(res);
            end
            FN_RD_CEN: begin
                if (w.row < NCLU) res.coord = VAL_W'(cen_coord[w.row*NDIM + w.dim]);
                expected_words.push_back(res);
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NPTS; i++) class_of[i] = '0;
            k_reg = 2;
            d_reg = 2;
            p_reg = 1024;
            mismatch_count = 0;
            expected_words.delete();
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_K: k_reg = pwdata[KREG_W-1:0];
                    REG_D: d_reg = pwdata[DREG_W-1:0];
                    REG_P: p_reg = pwdata[PREG_W-1:0];
                    default: ;
                endcase
            end
            if (out_mon.valid && out_mon.ready) check_word(out_mon.data);
            if (in_mon.valid && in_mon.ready) predict_word(in_mon.data);
        end
        pending_words = expected_words.size();
    end
endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import klm_pkg::*;

    localparam int          CYCLE_LIMIT = 4000000;
    localparam logic [2:0]  FN_SPARE_LO = FN_RD_CEN + 3'd1;
    localparam logic [2:0]  FN_SPARE_HI = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        steady;
    int          mismatch_count;
    int          pending_words;
    int          cyc;
    int          eff_k;
    int          eff_d;
    int          eff_p;
    bit          pt_written [1024*8];
    bit          cen_written [64];

    klm_in_if  in_ch ();
    klm_out_if out_ch ();

    kmeans_lloyd_iteration dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (in_ch),
        .m_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    kmeans_predict_check chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .in_mon         (in_ch),
        .out_mon        (out_ch),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_count (mismatch_count),
        .pending_words  (pending_words)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // cycle limit
    initial cyc = 0;
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        out_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= 35);
    end

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(7))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2, 3: return 16'($urandom_range(400)) - 16'sd200;
            default: return 16'($urandom);
        endcase
    endfunction

    // send one word, random gap in front unless steady
    task automatic send_word(input t_in_word w);
        if (!steady) begin
            while ($urandom_range(99) < 35) begin
                in_ch.valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        @(negedge i_clk);
        if (w.func == FN_LOAD_PT) pt_written[w.row*8 + w.dim] = 1'b1;
        if (w.func == FN_LOAD_CEN && w.row < 8) cen_written[w.row*8 + w.dim] = 1'b1;
    endtask

    task automatic issue(input logic [2:0] f, input int row, input int dim,
                         input logic signed [15:0] v);
        t_in_word w;
        w.func  = f;
        w.row   = ROW_W'(row);
        w.dim   = DIM_W'(dim);
        w.value = v;
        send_word(w);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // drain, then reprogram the engine
    task automatic reconfigure(input int k, input int d, input int p);
        in_ch.valid <= 1'b0;
        while (pending_words != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        apb_write(REG_K, k);
        apb_write(REG_D, d);
        apb_write(REG_P, p);
        k = k & 15;
        d = d & 15;
        p = p & 2047;
        eff_k = (k == 0) ? 1 : ((k > 8) ? 8 : k);
        eff_d = (d == 0) ? 1 : ((d > 8) ? 8 : d);
        eff_p = (p > 1024) ? 1024 : p;
    endtask

    // make sure a run touches only written coordinates
    task automatic fill_in_use();
        for (int i = 0; i < eff_p; i++)
            for (int j = 0; j < eff_d; j++)
                if (!pt_written[i*8+j]) issue(FN_LOAD_PT, i, j, rand_coord());
        for (int c = 0; c < eff_k; c++)
            for (int j = 0; j < eff_d; j++)
                if (!cen_written[c*8+j]) issue(FN_LOAD_CEN, c, j, rand_coord());
    endtask

    task automatic random_item();
        int r;
        int run_hi;
        int row;
        int dim;
        r = $urandom_range(99);
        // large point counts would need a full store fill, so no runs there
        run_hi = 55 + ((eff_p > 256) ? 0 : 10);
        dim = $urandom_range(7);
        if (r < 40) begin
            row = ($urandom_range(9) == 0 || eff_p == 0) ? $urandom_range(1023)
                                                         : $urandom_range(eff_p - 1);
            issue(FN_LOAD_PT, row, dim, rand_coord());
        end else if (r < 55) begin
            row = ($urandom_range(15) == 0) ? $urandom_range(1023) : $urandom_range(7);
            issue(FN_LOAD_CEN, row, dim, rand_coord());
        end else if (r < run_hi) begin
            fill_in_use();
            issue(FN_RUN, $urandom_range(1023), dim, 16'($urandom));
        end else if (r < 80) begin
            issue(FN_RD_CLASS, $urandom_range(1023), dim, 16'($urandom));
        end else if (r < 95) begin
            row = $urandom_range(7);
            if (!cen_written[row*8+dim]) row = $urandom_range(8, 1023);
            issue(FN_RD_CEN, row, dim, 16'($urandom));
        end else begin
            issue(3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI)), $urandom_range(1023), dim,
                  16'($urandom));
        end
    endtask

    task automatic random_phase(input int n);
        repeat (n) random_item();
    endtask

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        steady  = 1'b0;
        eff_k = 2;
        eff_d = 2;
        eff_p = 1024;
        i_rst_n = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset settings, never classified, out of range, spare codes
        issue(FN_RD_CLASS, 0, 0, 16'sd0);
        issue(FN_RD_CLASS, 1023, 7, 16'sd0);
        issue(FN_RD_CEN, 8, 7, 16'sd0);
        issue(FN_RD_CEN, 1023, 0, -16'sd1);
        issue(FN_SPARE_LO, 0, 0, 16'sd0);
        issue(FN_SPARE_LO + 3'd1, 1023, 7, -16'sd1);
        issue(FN_SPARE_HI, 5, 3, 16'sd77);
        issue(FN_LOAD_CEN, 0, 0, -16'sd32768);
        issue(FN_LOAD_CEN, 0, 1, -16'sd32768);
        issue(FN_LOAD_CEN, 1, 0, 16'sd32767);
        issue(FN_LOAD_CEN, 1, 1, 16'sd32767);
        issue(FN_LOAD_CEN, 9, 2, 16'sd5);
        issue(FN_LOAD_PT, 0, 0, 16'sd32767);
        issue(FN_LOAD_PT, 0, 1, -16'sd32768);
        issue(FN_LOAD_PT, 1023, 0, -16'sd32768);
        issue(FN_LOAD_PT, 1023, 1, 16'sd32767);
        issue(FN_LOAD_PT, 1023, 7, 16'sd1);
        reconfigure(2, 2, 4);
        fill_in_use();
        issue(FN_RUN, 0, 0, 16'sd0);
        issue(FN_RUN, 0, 0, 16'sd0);
        issue(FN_RD_CLASS, 0, 0, 16'sd0);
        issue(FN_RD_CLASS, 1023, 0, 16'sd0);
        issue(FN_RD_CEN, 0, 0, 16'sd0);
        issue(FN_RD_CEN, 1, 1, 16'sd0);

        // smallest settings
        reconfigure(1, 1, 1);
        random_phase(50);

        // all centroids equal: ties and empty clusters
        reconfigure(8, 8, 16);
        for (int c = 0; c < 8; c++)
            for (int j = 0; j < 8; j++) issue(FN_LOAD_CEN, c, j, 16'sd0);
        fill_in_use();
        issue(FN_RUN, 0, 0, 16'sd0);
        random_phase(50);

        // zero and overflowing register values, no points in use
        reconfigure(0, 15, 0);
        issue(FN_RUN, 0, 0, 16'sd0);
        random_phase(40);

        // no idling at all
        steady = 1'b1;
        reconfigure(4, 2, 64);
        random_phase(70);
        steady = 1'b0;

        reconfigure(15, 3, 40);
        random_phase(50);

        reconfigure(5, 4, 48);
        random_phase(50);

        // point count beyond the store saturates
        reconfigure(3, 1, 2047);
        random_phase(40);

        // largest cluster and dimension counts
        reconfigure(8, 8, 24);
        random_phase(40);

        reconfigure(2, 2, 8);
        random_phase(50);

        // drain and verdict
        in_ch.valid <= 1'b0;
        while (pending_words != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (mismatch_count == 0 && pending_words == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

>>> sim.f
rtl/klm_pkg.sv
rtl/klm_if.sv
rtl/klm_ram.sv
rtl/klm_cell.sv
rtl/klm_div.sv
rtl/kmeans_lloyd_iteration.sv
tb/sv/kmeans_predict_check.sv
tb/sv/tb_top.sv
